// ===== rtl/core/rgbir_pkg.sv =====
package rgbir_pkg;

  // Interpolation kernels, named by the 2x2 neighbourhood seen from the centre
  typedef enum logic [2:0] {
    K_GIBG,
    K_IGGR,
    K_BGGI,
    K_GRIG,
    K_GIRG,
    K_IGGB,
    K_RGGI,
    K_GBIG
  } kernel_t;

  // Line phases carried in tuser
  typedef enum logic [1:0] {
    PAT_BGGI = 2'd0,
    PAT_GIRG = 2'd1,
    PAT_RGGI = 2'd2,
    PAT_GIBG = 2'd3
  } line_pat_t;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned COL_W  = 12;
  localparam int unsigned CFG_W  = 13;
  localparam int unsigned SAMP_W = 3 * PIX_W;
  localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 13'd640;

  // Kernel for a line phase and the column phase of the centre pixel
  function automatic kernel_t kernel_sel(input line_pat_t pat, input logic [1:0] ph);
    kernel_t k;
    k = K_BGGI;
    case (pat)
      PAT_BGGI: begin
        case (ph)
          2'd0:    k = K_BGGI;
          2'd1:    k = K_GRIG;
          2'd2:    k = K_RGGI;
          default: k = K_GBIG;
        endcase
      end
      PAT_GIRG: begin
        case (ph)
          2'd0:    k = K_GIRG;
          2'd1:    k = K_IGGB;
          2'd2:    k = K_GIBG;
          default: k = K_IGGR;
        endcase
      end
      PAT_RGGI: begin
        case (ph)
          2'd0:    k = K_RGGI;
          2'd1:    k = K_GBIG;
          2'd2:    k = K_BGGI;
          default: k = K_GRIG;
        endcase
      end
      default: begin
        case (ph)
          2'd0:    k = K_GIBG;
          2'd1:    k = K_IGGR;
          2'd2:    k = K_GIRG;
          default: k = K_IGGB;
        endcase
      end
    endcase
    return k;
  endfunction

  // Truncating divide by three for sums of three samples (at most 765)
  function automatic logic [PIX_W-1:0] div3(input logic [9:0] s);
    logic [20:0] p;
    p = 21'(s) * 21'd683;
    return p[18:11];
  endfunction

endpackage

// ===== rtl/core/rgbir_debayer_5x3.sv =====
// A result word is registered and appears in the cycle after the column word that completes it.
// Throughput: one column word per cycle while out_tready allows; the first four columns of a line give no result.
// The rate is set by the single output register, which takes a word while the one
// it holds is being taken downstream.
// Reset (synchronous, rst_n low): window cleared, column count zero, line width 640.
module rgbir_debayer_5x3
  import rgbir_pkg::*;
#(
  parameter int unsigned MAX_LINE_WIDTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration: line_width
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // input column
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [SAMP_W-1:0]    in_tdata,   // top_pixel, mid_pixel, bottom_pixel
  input  logic [1:0]           in_tuser,   // line_pattern
  // output pixel
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [47:0]          out_tdata,  // ir, red, green, blue, pixel_column, pad
  output logic                 out_tlast   // line_end
);

  // Largest usable width: a multiple of four that the 13-bit register can reach
  localparam int unsigned CAP = (MAX_LINE_WIDTH > 8191) ? 8188 : (MAX_LINE_WIDTH / 4) * 4;
  localparam int unsigned CW  = $clog2(CAP);
  localparam logic [CFG_W-1:0] CAP_W = CFG_W'(CAP);

  function automatic logic [CFG_W-1:0] eff_width(input logic [CFG_W-1:0] lw);
    logic [CFG_W-1:0] w;
    w = {lw[CFG_W-1:2], 2'b00};
    if (w < CFG_W'(8)) w = CFG_W'(8);
    if (w > CAP_W) w = CAP_W;
    return w;
  endfunction

  logic [CFG_W-1:0]  width_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [SAMP_W-1:0] win_r [4];

  logic              out_valid_r;
  logic [PIX_W-1:0]  ir_r, red_r, green_r, blue_r;
  logic [COL_W-1:0]  col_r;
  logic              last_r;

  logic              in_fire;
  logic              has_res;
  logic              line_last;
  logic [CFG_W:0]    j_inc;
  kernel_t           kern;
  logic [PIX_W-1:0]  t [5];
  logic [PIX_W-1:0]  m [5];
  logic [PIX_W-1:0]  b [5];
  logic [PIX_W-1:0]  ir_nxt, red_nxt, green_nxt, blue_nxt;
  logic [PIX_W-1:0]  cross4, diag4;
  logic [PIX_W-1:0]  mid_lr, vert_tb, m13, tlbr, trbl;
  logic [PIX_W-1:0]  tri_tb, tri_bt;
  logic [9:0]        s_cross, s_diag, s_tri_tb, s_tri_bt;
  logic [8:0]        s_mlr, s_vtb, s_m13, s_tlbr, s_trbl;

  // Handshake
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Line position
  assign j_inc     = (CFG_W + 1)'(count_r) + (CFG_W + 1)'(1);
  assign line_last = j_inc >= {1'b0, width_r};
  assign has_res   = count_r >= CW'(4);
  assign count_nxt = line_last ? '0 : CW'(j_inc);
  assign kern      = kernel_sel(line_pat_t'(in_tuser), count_r[1:0]);

  // Unpack the five-column window, newest column straight from the input
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      t[i] = win_r[i][23:16];
      m[i] = win_r[i][15:8];
      b[i] = win_r[i][7:0];
    end
    t[4] = in_tdata[7:0];
    m[4] = in_tdata[15:8];
    b[4] = in_tdata[23:16];
  end

  // Neighbour sums and truncating averages
  always_comb begin
    s_cross  = 10'(t[2]) + 10'(m[1]) + 10'(m[3]) + 10'(b[2]);
    s_diag   = 10'(t[1]) + 10'(t[3]) + 10'(b[1]) + 10'(b[3]);
    s_tri_tb = 10'(t[2]) + 10'(b[0]) + 10'(b[4]);
    s_tri_bt = 10'(t[0]) + 10'(t[4]) + 10'(b[2]);
    s_mlr    = 9'(m[0]) + 9'(m[4]);
    s_vtb    = 9'(t[2]) + 9'(b[2]);
    s_m13    = 9'(m[1]) + 9'(m[3]);
    s_tlbr   = 9'(t[1]) + 9'(b[3]);
    s_trbl   = 9'(t[3]) + 9'(b[1]);
    cross4   = s_cross[9:2];
    diag4    = s_diag[9:2];
    tri_tb   = div3(s_tri_tb);
    tri_bt   = div3(s_tri_bt);
    mid_lr   = s_mlr[8:1];
    vert_tb  = s_vtb[8:1];
    m13      = s_m13[8:1];
    tlbr     = s_tlbr[8:1];
    trbl     = s_trbl[8:1];
  end

  // Kernel selection
  always_comb begin
    ir_nxt    = m[2];
    red_nxt   = trbl;
    green_nxt = cross4;
    blue_nxt  = tlbr;
    case (kern)
      K_GIBG: begin
        ir_nxt = diag4;   red_nxt = m[2];   green_nxt = cross4; blue_nxt = mid_lr;
      end
      K_IGGR: begin
        ir_nxt = vert_tb; red_nxt = m[1];   green_nxt = m[2];   blue_nxt = m[3];
      end
      K_BGGI: begin
        ir_nxt = m13;     red_nxt = tri_tb; green_nxt = m[2];   blue_nxt = tri_bt;
      end
      K_GRIG: begin
        ir_nxt = m[2];    red_nxt = tlbr;   green_nxt = cross4; blue_nxt = trbl;
      end
      K_GIRG: begin
        ir_nxt = diag4;   red_nxt = mid_lr; green_nxt = cross4; blue_nxt = m[2];
      end
      K_IGGB: begin
        ir_nxt = vert_tb; red_nxt = m[3];   green_nxt = m[2];   blue_nxt = m[1];
      end
      K_RGGI: begin
        ir_nxt = m13;     red_nxt = tri_bt; green_nxt = m[2];   blue_nxt = tri_tb;
      end
      default: begin
        ir_nxt = m[2];    red_nxt = trbl;   green_nxt = cross4; blue_nxt = tlbr;
      end
    endcase
  end

  // Width register and column counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= eff_width(LINE_WIDTH_RST);
      count_r <= '0;
    end else if (cfg_we) begin
      width_r <= eff_width(cfg_wdata);
      count_r <= '0;
    end else if (in_fire) begin
      count_r <= count_nxt;
    end
  end

  // Column window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) win_r[i] <= '0;
    end else if (in_fire) begin
      for (int i = 0; i < 3; i++) win_r[i] <= win_r[i + 1];
      win_r[3] <= {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_fire && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && has_res) begin
      ir_r    <= ir_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      col_r   <= COL_W'(count_r) - COL_W'(2);
      last_r  <= line_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, col_r, blue_r, green_r, red_r, ir_r};
  assign out_tlast  = last_r;

endmodule
